[hw/rtl/phfp_pkg.sv]
// Shared types, constants and lookup functions of the packet header parser.
package phfp_pkg;

  localparam int unsigned OffsetWidth = 7;
  localparam logic [OffsetWidth-1:0] OffsetMax      = 7'd127;
  localparam logic [OffsetWidth-1:0] OffEtypeHi     = 7'd12;
  localparam logic [OffsetWidth-1:0] OffEtypeLo     = 7'd13;
  localparam logic [OffsetWidth-1:0] OffVerIhl      = 7'd14;
  localparam logic [OffsetWidth-1:0] OffProtocol    = 7'd23;
  localparam logic [OffsetWidth-1:0] OffL4Base      = 7'd14;
  localparam logic [OffsetWidth-1:0] OffL4PortHi    = 7'd2;
  localparam logic [OffsetWidth-1:0] OffL4PortLo    = 7'd3;
  localparam logic [OffsetWidth-1:0] OffL4Flags     = 7'd13;

  localparam logic [15:0] EtypeArp  = 16'h0806;
  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [3:0]  IhlMask   = 4'hf;

  localparam logic [15:0] PortHttp   = 16'd80;
  localparam logic [15:0] PortHttps  = 16'd443;
  localparam logic [15:0] PortSsh    = 16'd22;
  localparam logic [15:0] PortTelnet = 16'd23;
  localparam logic [15:0] PortSmtp   = 16'd25;
  localparam logic [15:0] PortIrc    = 16'd6667;
  localparam logic [15:0] PortDns    = 16'd53;
  localparam logic [15:0] PortDhcpS  = 16'd67;
  localparam logic [15:0] PortDhcpC  = 16'd68;

  typedef enum logic [3:0] {
    APP_NONE   = 4'd0,
    APP_HTTP   = 4'd1,
    APP_HTTPS  = 4'd2,
    APP_SSH    = 4'd3,
    APP_TELNET = 4'd4,
    APP_SMTP   = 4'd5,
    APP_IRC    = 4'd6,
    APP_DNS    = 4'd7,
    APP_DHCP   = 4'd8
  } app_code_e;

  // seen flags
  typedef struct packed {
    logic flags;
    logic port;
    logic proto;
    logic etype;
  } seen_t;

  typedef struct packed {
    logic [15:0] etype_word;
    logic [3:0]  ihl;
    logic [7:0]  protocol;
    logic [15:0] dest_port;
    logic [7:0]  flags;
    seen_t       seen;
  } hdr_t;

  typedef struct packed {
    logic       is_arp;
    logic       is_ipv4;
    logic [5:0] ip_header_bytes;
    logic [7:0] ip_protocol;
    logic       is_tcp;
    logic       is_udp;
    logic [6:0] tcp_flag_bits;
    app_code_e  app_code;
    logic       short_packet;
  } result_t;

  function automatic app_code_e tcp_app(input logic [15:0] port);
    app_code_e code;
    case (port)
      PortHttp:   code = APP_HTTP;
      PortHttps:  code = APP_HTTPS;
      PortSsh:    code = APP_SSH;
      PortTelnet: code = APP_TELNET;
      PortSmtp:   code = APP_SMTP;
      PortIrc:    code = APP_IRC;
      default:    code = APP_NONE;
    endcase
    return code;
  endfunction

  function automatic app_code_e udp_app(input logic [15:0] port);
    app_code_e code;
    case (port)
      PortDns:   code = APP_DNS;
      PortDhcpS: code = APP_DHCP;
      PortDhcpC: code = APP_DHCP;
      default:   code = APP_NONE;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/phfp_intf.sv]
// Valid/ready channel interfaces for frame bytes and classification results.
interface phfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface phfp_out_if;
  logic       valid;
  logic       ready;
  logic       is_arp;
  logic       is_ipv4;
  logic [5:0] ip_header_bytes;
  logic [7:0] ip_protocol;
  logic       is_tcp;
  logic       is_udp;
  logic [6:0] tcp_flag_bits;
  logic [3:0] app_code;
  logic       short_packet;

  modport source (
    output valid, output is_arp, output is_ipv4, output ip_header_bytes,
    output ip_protocol, output is_tcp, output is_udp, output tcp_flag_bits,
    output app_code, output short_packet, input ready
  );
  modport sink (
    input valid, input is_arp, input is_ipv4, input ip_header_bytes,
    input ip_protocol, input is_tcp, input is_udp, input tcp_flag_bits,
    input app_code, input short_packet, output ready
  );
endinterface

[hw/rtl/phfp_capture.sv]
// Byte offset counter and header field capture for one frame.
module phfp_capture (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                last_i,
  input  logic [7:0]          byte_i,
  output phfp_pkg::hdr_t      hdr_o
);

  logic [phfp_pkg::OffsetWidth-1:0] off_q, off_d;
  logic [phfp_pkg::OffsetWidth-1:0] l4;
  phfp_pkg::hdr_t hdr_q, hdr_d;

  always_comb begin
    hdr_d = hdr_q;
    l4 = phfp_pkg::OffL4Base + {1'b0, hdr_q.ihl, 2'b00};
    if (off_q == phfp_pkg::OffEtypeHi) begin
      hdr_d.etype_word[15:8] = byte_i;
    end
    if (off_q == phfp_pkg::OffEtypeLo) begin
      hdr_d.etype_word[7:0] = byte_i;
      hdr_d.seen.etype = 1'b1;
    end
    if (off_q == phfp_pkg::OffVerIhl) begin
      hdr_d.ihl = byte_i[3:0] & phfp_pkg::IhlMask;
    end
    if (off_q == phfp_pkg::OffProtocol) begin
      hdr_d.protocol = byte_i;
      hdr_d.seen.proto = 1'b1;
    end
    if (off_q > phfp_pkg::OffVerIhl) begin
      if (off_q == l4 + phfp_pkg::OffL4PortHi) begin
        hdr_d.dest_port[15:8] = byte_i;
      end
      if (off_q == l4 + phfp_pkg::OffL4PortLo) begin
        hdr_d.dest_port[7:0] = byte_i;
        hdr_d.seen.port = 1'b1;
      end
      if (off_q == l4 + phfp_pkg::OffL4Flags) begin
        hdr_d.flags = byte_i;
        hdr_d.seen.flags = 1'b1;
      end
    end
    off_d = (off_q == phfp_pkg::OffsetMax) ? off_q : off_q + 7'd1;
  end

  assign hdr_o = hdr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      hdr_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        off_q <= '0;
        hdr_q <= '0;
      end else begin
        off_q <= off_d;
        hdr_q <= hdr_d;
      end
    end
  end

endmodule

[hw/rtl/phfp_classify.sv]
// Frame classification from the captured header fields.
module phfp_classify (
  input  phfp_pkg::hdr_t    hdr_i,
  output phfp_pkg::result_t res_o
);

  always_comb begin
    res_o = '0;
    res_o.app_code = phfp_pkg::APP_NONE;
    if (!hdr_i.seen.etype) begin
      res_o.short_packet = 1'b1;
    end else begin
      res_o.is_arp  = (hdr_i.etype_word == phfp_pkg::EtypeArp);
      res_o.is_ipv4 = (hdr_i.etype_word == phfp_pkg::EtypeIpv4);
    end
    if (res_o.is_ipv4) begin
      if (!hdr_i.seen.proto) begin
        res_o.short_packet = 1'b1;
      end else begin
        res_o.ip_header_bytes = {hdr_i.ihl, 2'b00};
        res_o.ip_protocol     = hdr_i.protocol;
        res_o.is_tcp          = (hdr_i.protocol == phfp_pkg::ProtoTcp);
        res_o.is_udp          = (hdr_i.protocol == phfp_pkg::ProtoUdp);
      end
    end
    if (res_o.is_tcp || res_o.is_udp) begin
      if (!hdr_i.seen.port) begin
        res_o.short_packet = 1'b1;
      end else if (res_o.is_tcp) begin
        res_o.app_code = phfp_pkg::tcp_app(hdr_i.dest_port);
      end else begin
        res_o.app_code = phfp_pkg::udp_app(hdr_i.dest_port);
      end
    end
    if (res_o.is_tcp) begin
      if (!hdr_i.seen.flags) begin
        res_o.short_packet = 1'b1;
      end else begin
        // urg (bit 5 of the wire byte) is dropped
        res_o.tcp_flag_bits = {hdr_i.flags[7:6], hdr_i.flags[4:0]};
      end
    end
  end

endmodule

[hw/rtl/packet_header_feature_parser_top.sv]
// Top level of the Ethernet/IPv4/TCP/UDP header parser.
// Takes one frame byte per cycle; a new byte may enter every cycle unless
// a last byte waits. Bytes are registered on entry, then captured into the
// header fields; on the last byte of a frame one classification request is
// written to the output register from the registered byte. Only a last
// byte waits, when the output register still holds an untaken request, and
// no byte enters behind it; other bytes flow on regardless of the output side.
module packet_header_feature_parser_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  phfp_in_if.sink       in_i,
  phfp_out_if.source    out_o
);

  logic       in_valid_q;
  logic       in_last_q;
  logic [7:0] in_byte_q;
  logic       step;
  logic       out_valid_q;
  phfp_pkg::hdr_t    hdr;
  phfp_pkg::result_t res, res_q;

  assign step = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_last_q <= in_i.last_byte;
      in_byte_q <= in_i.data_byte;
    end
  end

  phfp_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .last_i (in_last_q),
    .byte_i (in_byte_q),
    .hdr_o  (hdr)
  );

  phfp_classify u_classify (
    .hdr_i (hdr),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.is_arp          = res_q.is_arp;
  assign out_o.is_ipv4         = res_q.is_ipv4;
  assign out_o.ip_header_bytes = res_q.ip_header_bytes;
  assign out_o.ip_protocol     = res_q.ip_protocol;
  assign out_o.is_tcp          = res_q.is_tcp;
  assign out_o.is_udp          = res_q.is_udp;
  assign out_o.tcp_flag_bits   = res_q.tcp_flag_bits;
  assign out_o.app_code        = res_q.app_code;
  assign out_o.short_packet    = res_q.short_packet;

endmodule
